>>> hdl/apt_pkg.sv
// ----------------------------------------------------------------------------
// apt_pkg: shared types and constants of the animation progress timer
// Field widths, mode codes, register indexes and controller/datapath structs.
// ----------------------------------------------------------------------------
package apt_pkg;

    localparam int TIME_W = 32;
    localparam int PROG_W = 17;
    localparam int MODE_W = 17;
    localparam int FRAC_W = 16;
    localparam int QUO_W  = TIME_W + FRAC_W;
    localparam int STEP_W = 6;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    // The divider produces one quotient bit per cycle over the full 48-bit dividend.
    localparam logic [STEP_W-1:0] DIV_LAST_STEP = STEP_W'(QUO_W - 1);

    localparam logic [TIME_W-1:0] PERIOD_RST   = 32'd1000;
    localparam logic [MODE_W-1:0] MODE_ONESHOT = '0;
    localparam logic [MODE_W-1:0] MODE_LOOP    = '1;
    localparam logic [PROG_W-1:0] PROG_FULL    = 17'h10000;

    localparam logic ACT_ARM   = 1'b0;
    localparam logic ACT_FRAME = 1'b1;

    localparam logic REG_PERIOD = 1'b0;
    localparam logic REG_REPEAT = 1'b1;

    typedef struct packed {
        logic arm;
        logic idle_frame;
        logic load;
        logic step;
        logic commit;
    } apt_cmd_t;

    typedef struct packed {
        logic running;
        logic out_free;
    } apt_sts_t;

endpackage

>>> hdl/apt_if.sv
// ----------------------------------------------------------------------------
// apt_if: valid/ready channels of the animation progress timer
// Command channel (arm or frame) and result channel.
// ----------------------------------------------------------------------------
interface apt_cmd_if import apt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              action;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, action, now_ms, input ready);
    modport sink   (input valid, action, now_ms, output ready);
endinterface

interface apt_res_if import apt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [PROG_W-1:0] progress;
    logic              first_frame;
    logic              final_frame;

    modport source (output valid, progress, first_frame, final_frame, input ready);
    modport sink   (input valid, progress, first_frame, final_frame, output ready);
endinterface

>>> hdl/animation_progress_timer_top.sv
// ----------------------------------------------------------------------------
// animation_progress_timer_top: frame-driven animation progress timer
// Turns millisecond frame times into Q16 round progress with round marks.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one item per transfer: action 0 arms the animation and clears
//   its timing state, action 1 is a frame with the current time in now_ms.
//   result carries progress (Q16, 65536 is a complete round) and the
//   first_frame and final_frame marks. The APB port sets period_ms and
//   repeat_mode; write them only while the block is idle.
// Sequence:
//   An arm item, or a frame while the animation is stopped, gives no result.
//   A frame while running is loaded, the restoring divider produces one
//   quotient bit per cycle (32 bits of whole rounds, 16 bits of fraction)
//   and the result is committed; no new item is taken before the commit.
// Reset:
//   rst_n clears the animation to stopped and the registers to a period of
//   1000 ms and one-shot mode.
// Stalls:
//   A result waits in the output register while result.ready is low; the next
//   item is still taken, and its commit waits until the output is free.
// ----------------------------------------------------------------------------
module animation_progress_timer_top import apt_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    apt_cmd_if.sink           cmd,
    apt_res_if.source         result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic [TIME_W-1:0] period_ms;
    logic [MODE_W-1:0] repeat_mode;
    apt_cmd_t          ctl_cmd;
    apt_sts_t          dp_sts;

    apt_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .period_ms   (period_ms),
        .repeat_mode (repeat_mode)
    );

    apt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_action (cmd.action),
        .in_ready  (cmd.ready),
        .sts       (dp_sts),
        .cmd       (ctl_cmd)
    );

    apt_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (ctl_cmd),
        .sts         (dp_sts),
        .now_ms      (cmd.now_ms),
        .period_ms   (period_ms),
        .repeat_mode (repeat_mode),
        .out_ready   (result.ready),
        .out_valid   (result.valid),
        .progress    (result.progress),
        .first_frame (result.first_frame),
        .final_frame (result.final_frame)
    );

endmodule

>>> hdl/apt_cfg.sv
// ----------------------------------------------------------------------------
// apt_cfg: APB register file
// Holds the round period and the repeat mode.
// ----------------------------------------------------------------------------
module apt_cfg import apt_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output logic [TIME_W-1:0] period_ms,
    output logic [MODE_W-1:0] repeat_mode
);

    logic [TIME_W-1:0] period_reg;
    logic [MODE_W-1:0] repeat_reg;
    logic              wr_en;
    logic              reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RST;
            repeat_reg <= MODE_ONESHOT;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_PERIOD: period_reg <= pwdata[TIME_W-1:0];
                REG_REPEAT: repeat_reg <= pwdata[MODE_W-1:0];
                default:    period_reg <= period_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_PERIOD: prdata = period_reg;
            REG_REPEAT: prdata = {{(DATA_W-MODE_W){repeat_reg[MODE_W-1]}}, repeat_reg};
            default:    prdata = '0;
        endcase
    end

    assign period_ms   = period_reg;
    assign repeat_mode = repeat_reg;

endmodule

>>> hdl/apt_ctrl.sv
// ----------------------------------------------------------------------------
// apt_ctrl: sequencer of the animation progress timer
// Accepts items, runs the serial divider and commits each frame result.
// ----------------------------------------------------------------------------
module apt_ctrl import apt_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_action,
    output logic     in_ready,
    input  apt_sts_t sts,
    output apt_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_FIN  = 3'b100
    } apt_state_t;

    apt_state_t        state_reg, state_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_action == ACT_ARM)
                        cmd.arm = 1'b1;
                    else if (!sts.running)
                        cmd.idle_frame = 1'b1;
                    else
                    begin
                        cmd.load   = 1'b1;
                        cnt_next   = '0;
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST_STEP)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                // Hold the finished frame until the output register can take it.
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_full_division: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FIN |-> cnt_reg == DIV_LAST_STEP + 1'b1)
        else $error("frame committed before all quotient bits were produced");

    a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |=> state_reg == S_DIV || state_reg == S_FIN)
        else $error("division interrupted");

endmodule

>>> hdl/apt_dp.sv
// ----------------------------------------------------------------------------
// apt_dp: datapath of the animation progress timer
// Timing state, a one-bit-per-cycle restoring divider and the result register.
// ----------------------------------------------------------------------------
module apt_dp import apt_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  apt_cmd_t          cmd,
    output apt_sts_t          sts,
    input  logic [TIME_W-1:0] now_ms,
    input  logic [TIME_W-1:0] period_ms,
    input  logic [MODE_W-1:0] repeat_mode,
    input  logic              out_ready,
    output logic              out_valid,
    output logic [PROG_W-1:0] progress,
    output logic              first_frame,
    output logic              final_frame
);

    logic              running_reg;
    logic              started_reg;
    logic [TIME_W-1:0] start_reg;
    logic [PROG_W-1:0] cur_prog_reg;
    logic [PROG_W-1:0] prev_prog_reg;
    logic [TIME_W-1:0] prev_round_reg;
    logic              out_valid_reg;

    logic [TIME_W-1:0] now_reg;
    logic [TIME_W-1:0] rem_reg;
    logic [QUO_W-1:0]  acc_reg;
    logic [PROG_W-1:0] out_prog_reg;
    logic              out_first_reg;
    logic              out_final_reg;

    logic [TIME_W-1:0] per;
    logic              fresh;
    logic [TIME_W-1:0] gap;
    logic [TIME_W:0]   trial;
    logic              q_bit;
    logic [TIME_W:0]   rem_diff;

    logic [TIME_W-1:0] rounds;
    logic [PROG_W-1:0] frac;
    logic [TIME_W-1:0] limit;
    logic [PROG_W-1:0] res_prog;
    logic              res_first;
    logic              res_final;
    logic              emit;
    logic              run_after;
    logic [PROG_W-1:0] prev_prog_new;
    logic [TIME_W-1:0] prev_round_new;

    assign per   = (period_ms == '0) ? TIME_W'(1) : period_ms;
    assign fresh = (cur_prog_reg == '0) && !started_reg;
    // On the very first frame the start time is taken from this frame, so the gap is zero.
    assign gap   = fresh ? '0 : now_ms - start_reg;

    // The dividend is gap * 65536: the upper quotient bits are whole rounds, the
    // lower sixteen are the Q16 fraction of the current round.
    assign trial    = {rem_reg, acc_reg[QUO_W-1]};
    assign q_bit    = trial >= {1'b0, per};
    assign rem_diff = q_bit ? trial - {1'b0, per} : trial;

    assign rounds = acc_reg[QUO_W-1:FRAC_W];
    assign frac   = {1'b0, acc_reg[FRAC_W-1:0]};
    assign limit  = {{(TIME_W-MODE_W){repeat_mode[MODE_W-1]}}, repeat_mode};

    always_comb
    begin
        res_prog       = frac;
        res_first      = (cur_prog_reg == '0);
        res_final      = 1'b0;
        emit           = 1'b1;
        run_after      = 1'b1;
        prev_prog_new  = prev_prog_reg;
        prev_round_new = prev_round_reg;
        if (repeat_mode == MODE_ONESHOT)
        begin
            if (rounds != '0)
            begin
                res_prog  = PROG_FULL;
                res_final = 1'b1;
                run_after = 1'b0;
            end
        end
        else if (repeat_mode == MODE_LOOP)
        begin
            if (frac < prev_prog_reg)
            begin
                res_first = 1'b1;
                res_final = 1'b1;
            end
            prev_prog_new = frac;
        end
        else
        begin
            if (rounds > limit)
            begin
                run_after = 1'b0;
                emit      = 1'b0;
            end
            else
            begin
                if (rounds > prev_round_reg)
                    res_first = 1'b1;
                prev_round_new = rounds;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg    <= 1'b0;
            started_reg    <= 1'b0;
            start_reg      <= '0;
            cur_prog_reg   <= '0;
            prev_prog_reg  <= '0;
            prev_round_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.arm)
            begin
                running_reg    <= 1'b1;
                started_reg    <= 1'b0;
                start_reg      <= '0;
                cur_prog_reg   <= '0;
                prev_prog_reg  <= '0;
                prev_round_reg <= '0;
            end
            if (cmd.idle_frame)
                start_reg <= now_ms;
            if (cmd.load && fresh)
            begin
                started_reg <= 1'b1;
                start_reg   <= now_ms;
            end
            if (cmd.commit)
            begin
                running_reg    <= run_after;
                prev_prog_reg  <= prev_prog_new;
                prev_round_reg <= prev_round_new;
                if (emit)
                    cur_prog_reg <= res_prog;
                if (!run_after)
                    start_reg <= now_reg;
            end
            if (cmd.commit && emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            now_reg <= now_ms;
            rem_reg <= '0;
            acc_reg <= {gap, {FRAC_W{1'b0}}};
        end
        else if (cmd.step)
        begin
            rem_reg <= rem_diff[TIME_W-1:0];
            acc_reg <= {acc_reg[QUO_W-2:0], q_bit};
        end
        if (cmd.commit && emit)
        begin
            out_prog_reg  <= res_prog;
            out_first_reg <= res_first;
            out_final_reg <= res_final;
        end
    end

    assign sts.running  = running_reg;
    assign sts.out_free = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign progress    = out_prog_reg;
    assign first_frame = out_first_reg;
    assign final_frame = out_final_reg;

    a_prog_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_prog_reg <= PROG_FULL)
        else $error("progress above one full round");

    a_full_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_prog_reg == PROG_FULL |-> out_final_reg)
        else $error("complete progress without the last-frame mark");

endmodule

>>> tb/sv/apt_checker.sv
// ----------------------------------------------------------------------------
// apt_checker: scoreboard for the animation progress timer
// Follows register writes and command transfers, predicts each frame's
// progress and round marks, and compares every result transfer in order.
// ----------------------------------------------------------------------------
module apt_checker import apt_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  logic              cmd_ready,
    input  logic              cmd_action,
    input  logic [TIME_W-1:0] cmd_now,
    input  logic              res_valid,
    input  logic              res_ready,
    input  logic [PROG_W-1:0] res_progress,
    input  logic              res_first,
    input  logic              res_final,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output int                errors,
    output int                pending,
    output int                results
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [PROG_W-1:0] progress;
        logic              first_frame;
        logic              final_frame;
    } frame_mark_t;

    frame_mark_t       marks_q[$];

    logic [TIME_W-1:0] period_reg;
    logic [MODE_W-1:0] repeat_reg;
    logic              running;
    logic              started;
    logic [TIME_W-1:0] start_time;
    logic [PROG_W-1:0] cur_prog;
    logic [PROG_W-1:0] prev_prog;
    logic [TIME_W-1:0] prev_round;

    task automatic clear_timing();
        started    = 1'b0;
        start_time = '0;
        cur_prog   = '0;
        prev_prog  = '0;
        prev_round = '0;
    endtask

    // Applies one command to the timer state and queues the result it causes.
    task automatic advance_timer(input logic act, input logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] per;
        logic [TIME_W-1:0] gap;
        logic [TIME_W-1:0] rounds;
        logic [TIME_W-1:0] limit;
        logic [63:0]       frac_wide;
        logic [PROG_W-1:0] frac;
        logic              first_mark;
        logic              last_mark;
        logic              emit;
        frame_mark_t       mark;

        if (act == ACT_ARM)
        begin
            running = 1'b1;
            clear_timing();
            return;
        end
        if (running)
        begin
            per        = (period_reg == '0) ? 32'd1 : period_reg;
            first_mark = 1'b0;
            last_mark  = 1'b0;
            emit       = 1'b1;
            if (cur_prog == '0)
            begin
                first_mark = 1'b1;
                if (!started)
                begin
                    started    = 1'b1;
                    start_time = now;
                end
            end
            gap       = now - start_time;
            rounds    = gap / per;
            frac_wide = {16'd0, gap % per, 16'd0} / {32'd0, per};
            frac      = frac_wide[PROG_W-1:0];

            if (repeat_reg == MODE_ONESHOT)
            begin
                if (rounds >= 32'd1)
                begin
                    last_mark = 1'b1;
                    frac      = PROG_FULL;
                    running   = 1'b0;
                end
            end
            else if (repeat_reg == MODE_LOOP)
            begin
                if (frac < prev_prog)
                begin
                    first_mark = 1'b1;
                    last_mark  = 1'b1;
                end
                prev_prog = frac;
            end
            else
            begin
                // Negative counts other than loop become huge unsigned limits.
                limit = {{(TIME_W-MODE_W){repeat_reg[MODE_W-1]}}, repeat_reg};
                if (rounds > limit)
                begin
                    running = 1'b0;
                    emit    = 1'b0;
                end
                else
                begin
                    if (rounds > prev_round)
                        first_mark = 1'b1;
                    prev_round = rounds;
                end
            end

            if (emit)
            begin
                cur_prog         = frac;
                mark.progress    = frac;
                mark.first_frame = first_mark;
                mark.final_frame = last_mark;
                marks_q.push_back(mark);
            end
        end
        if (!running)
            start_time = now;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        frame_mark_t want;
        if (!rst_n)
        begin
            marks_q.delete();
            period_reg = PERIOD_RST;
            repeat_reg = MODE_ONESHOT;
            running    = 1'b0;
            clear_timing();
            errors     = 0;
            results    = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[ADDR_W-1:2] == REG_PERIOD)
                    period_reg = pwdata[TIME_W-1:0];
                else if (paddr[ADDR_W-1:2] == REG_REPEAT)
                    repeat_reg = pwdata[MODE_W-1:0];
            end

            if (res_valid && res_ready)
            begin
                results++;
                if (marks_q.size() == 0)
                begin
                    $error("unexpected result transfer: progress %0d first %0b final %0b",
                           res_progress, res_first, res_final);
                    errors++;
                end
                else
                begin
                    want = marks_q.pop_front();
                    if (res_progress !== want.progress)
                    begin
                        $error("progress: expected %0d, got %0d", want.progress, res_progress);
                        errors++;
                    end
                    if (res_first !== want.first_frame)
                    begin
                        $error("first_frame: expected %0b, got %0b",
                               want.first_frame, res_first);
                        errors++;
                    end
                    if (res_final !== want.final_frame)
                    begin
                        $error("final_frame: expected %0b, got %0b",
                               want.final_frame, res_final);
                        errors++;
                    end
                end
            end

            if (cmd_valid && cmd_ready)
                advance_timer(cmd_action, cmd_now);
        end
        pending = marks_q.size();
    end

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the animation progress timer
// Drives arm and frame commands through one-shot, loop and counted modes
// under several periods, with random sender gaps, result stalls and a long
// result hold-off; a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench import apt_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = 64;
    localparam int HOLD_CYCLES  = 400;
    localparam logic [ADDR_W-1:0] ADDR_PERIOD = ADDR_W'({REG_PERIOD, 2'b00});
    localparam logic [ADDR_W-1:0] ADDR_REPEAT = ADDR_W'({REG_REPEAT, 2'b00});

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int                chk_errors;
    int                chk_pending;
    int                chk_results;

    int                send_idle_pct = 0;
    int                stall_pct = 0;
    int                hold_len = 0;
    int                n_items = 0;
    int                n_arms = 0;
    int                n_settings = 0;
    logic [TIME_W-1:0] cur_period = PERIOD_RST;
    int unsigned       jump_max = 3;

    apt_cmd_if cmd_ch();
    apt_res_if res_ch();

    animation_progress_timer_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_ch),
        .result  (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    apt_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_ch.valid),
        .cmd_ready    (cmd_ch.ready),
        .cmd_action   (cmd_ch.action),
        .cmd_now      (cmd_ch.now_ms),
        .res_valid    (res_ch.valid),
        .res_ready    (res_ch.ready),
        .res_progress (res_ch.progress),
        .res_first    (res_ch.first_frame),
        .res_final    (res_ch.final_frame),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .errors       (chk_errors),
        .pending      (chk_pending),
        .results      (chk_results)
    );

    always #6 clk = ~clk;

    initial
    begin
        #10ms;
        $display("Test completed with failures");
        $finish;
    end

    // Result side: random stalls, or one long hold-off when requested.
    initial
    begin
        int held;
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_len != 0)
            begin
                res_ch.ready <= 1'b0;
                held = 0;
                while (held < hold_len)
                begin
                    @(posedge clk);
                    held++;
                end
                hold_len = 0;
            end
            else
                res_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Leaves valid high after the transfer so back-to-back items never toggle it.
    task automatic send_item(input logic act, input logic [TIME_W-1:0] now);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid  <= 1'b1;
        cmd_ch.action <= act;
        cmd_ch.now_ms <= now;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        n_items++;
        if (act == ACT_ARM)
            n_arms++;
    endtask

    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (chk_pending != 0);
        // A frame that stops a counted animation gives no result but keeps
        // the divider busy for a while.
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(input logic [TIME_W-1:0] per, input logic [MODE_W-1:0] rep);
        wait_drained();
        reg_write(ADDR_PERIOD, per);
        reg_write(ADDR_REPEAT, {{(DATA_W-MODE_W){rep[MODE_W-1]}}, rep});
        cur_period = per;
        if (rep != MODE_ONESHOT && rep != MODE_LOOP && !rep[MODE_W-1])
            jump_max = rep / 5 + 2;
        else
            jump_max = 3;
        n_settings++;
    endtask

    // Next frame time: mostly small steps, with period edges and long jumps.
    function automatic logic [TIME_W-1:0] next_time(input logic [TIME_W-1:0] t);
        logic [TIME_W-1:0] p;
        p = (cur_period == '0) ? 32'd1 : cur_period;
        case ($urandom_range(9))
            0:          return t;
            1, 2, 3, 4: return t + $urandom_range(p / 3);
            5:          return t + p;
            6:          return t + p - 32'd1;
            7:          return t + p * $urandom_range(jump_max);
            8:          return t + $urandom();
            default:    return t + $urandom_range(2 * p);
        endcase
    endfunction

    task automatic frame_run(input int len);
        logic [TIME_W-1:0] t;
        send_item(ACT_ARM, $urandom());
        t = $urandom();
        repeat (len)
        begin
            send_item(ACT_FRAME, t);
            t = next_time(t);
        end
    endtask

    task automatic run_phase(input logic [TIME_W-1:0] per, input logic [MODE_W-1:0] rep,
                             input int idle_pct, input int stall, input int count);
        int start_items;
        set_config(per, rep);
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        start_items   = n_items;
        while (n_items - start_items < count)
        begin
            if ($urandom_range(99) < 85)
                frame_run($urandom_range(15, 2));
            else
                repeat ($urandom_range(3, 1))
                    send_item(logic'($urandom_range(1)), $urandom());
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        cmd_ch.valid  = 1'b0;
        cmd_ch.action = ACT_ARM;
        cmd_ch.now_ms = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: one-shot with a 1000 ms period, start near the time wrap.
        send_item(ACT_FRAME, 32'd0);
        send_item(ACT_ARM, 32'd0);
        send_item(ACT_FRAME, 32'hFFFF_FF00);
        send_item(ACT_FRAME, 32'hFFFF_FF00 + 32'd500);
        send_item(ACT_FRAME, 32'hFFFF_FF00 + 32'd999);
        send_item(ACT_FRAME, 32'hFFFF_FF00 + 32'd1000);
        send_item(ACT_FRAME, 32'hFFFF_FFFF);

        // Loop mode wrapping back to zero progress.
        set_config(32'd3, MODE_LOOP);
        send_item(ACT_ARM, 32'hFFFF_FFFF);
        for (int t = 10; t <= 14; t++)
            send_item(ACT_FRAME, TIME_W'(t));

        // Zero period acts as one; a count of two stops after the third round.
        set_config(32'd0, 17'd2);
        send_item(ACT_ARM, 32'd0);
        for (int t = 100; t <= 104; t++)
            send_item(ACT_FRAME, TIME_W'(t));

        // Longest period with a negative count that never stops.
        set_config(32'hFFFF_FFFF, 17'h10000);
        send_item(ACT_ARM, 32'd0);
        send_item(ACT_FRAME, 32'd0);
        send_item(ACT_FRAME, 32'hFFFF_FFFE);
        send_item(ACT_FRAME, 32'hFFFF_FFFF);

        run_phase(32'd1000, MODE_ONESHOT, 0, 0, 60);
        run_phase(32'd1, MODE_LOOP, 49, 0, 60);
        run_phase($urandom_range(5000, 2), MODE_W'($urandom_range(8, 1)), 0, 49, 60);
        run_phase(32'hFFFF_FFFF, 17'd65535, 15, 15, 60);

        run_phase($urandom_range(3000, 1), MODE_LOOP, 0, 0, 60);
        // Hold the result side off while frames keep coming, then let it all drain.
        send_idle_pct = 0;
        hold_len      = HOLD_CYCLES;
        frame_run(14);
        wait_drained();

        run_phase($urandom_range(300, 1), MODE_ONESHOT, 49, 0, 60);
        run_phase($urandom(), MODE_W'($urandom_range(17'h1FFFE, 17'h10000)), 0, 49, 60);
        run_phase($urandom(), MODE_LOOP, 15, 15, 60);
        run_phase(32'd7, MODE_W'($urandom_range(40, 9)), 49, 49, 60);

        wait_drained();
        if (chk_pending != 0)
            $error("%0d expected results never arrived", chk_pending);
        $display("Sent %0d command transfers (%0d arms) over %0d register settings.",
                 n_items, n_arms, n_settings);
        $display("Checked %0d results in one-shot, loop and counted modes under stalls.",
                 chk_results);
        if (chk_errors == 0 && chk_pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
